[sv/urbp_pkg.sv]
// urbp_pkg: shared types, field layout and result packing for the uart ring buffer pair
// no dependencies; used by urbp_ring, urbp_out and uart_ring_buffer_pair
`timescale 1ns / 1ps

package urbp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LevelW = 10;
  localparam int unsigned InW    = 24;
  localparam int unsigned OutW   = 48;

  // input item layout, lowest bit up
  localparam int unsigned InWrValid = 0;
  localparam int unsigned InWrByte  = 1;
  localparam int unsigned InRdReq   = 9;
  localparam int unsigned InTxReady = 10;
  localparam int unsigned InRxValid = 11;
  localparam int unsigned InRxByte  = 12;

  // per-ring status seen by the top level
  typedef struct packed {
    logic push_ok;
    logic pop_ok;
    logic empty_nxt;
    logic full_nxt;
  } urbp_ring_st_t;

  // result fields held between the ring access and the output register
  typedef struct packed {
    logic              write_accepted;
    logic              read_valid;
    logic              tx_out_valid;
    logic              rx_taken;
    logic              tx_irq_enable;
    logic              rx_irq_enable;
    logic [LevelW-1:0] tx_level;
    logic [LevelW-1:0] rx_level;
  } urbp_flags_t;

  function automatic logic [OutW-1:0] pack_result(urbp_flags_t f, logic [ByteW-1:0] rd_byte,
                                                  logic [ByteW-1:0] tx_byte);
    logic [ByteW-1:0] rd_m;
    logic [ByteW-1:0] tx_m;
    rd_m = f.read_valid ? rd_byte : '0;
    tx_m = f.tx_out_valid ? tx_byte : '0;
    return {6'b0, f.rx_level, f.tx_level, f.rx_irq_enable, f.tx_irq_enable, f.rx_taken,
            tx_m, f.tx_out_valid, rd_m, f.read_valid, f.write_accepted};
  endfunction

endpackage

[sv/urbp_ring.sv]
// urbp_ring: one byte ring, head/tail/count registers around a synchronous store
// uses urbp_pkg for the status struct and level width
`timescale 1ns / 1ps

module urbp_ring #(
  parameter int unsigned DEPTH = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        push_i,
  input  logic [urbp_pkg::ByteW-1:0]  push_data_i,
  input  logic                        pop_i,
  output urbp_pkg::urbp_ring_st_t     st_o,
  output logic [urbp_pkg::LevelW-1:0] level_o,
  output logic [urbp_pkg::ByteW-1:0]  rdata_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC  = CW'(DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  logic [urbp_pkg::ByteW-1:0] mem [DEPTH];
  logic [urbp_pkg::ByteW-1:0] rdata_q;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic push_ok, pop_ok, wr_en, rd_en;
  logic [CW+urbp_pkg::LevelW-1:0] level_ext;

  // decisions on the count from before the item
  assign push_ok = push_i && (count_q != DepthC);
  assign pop_ok  = pop_i && (count_q != '0);
  assign wr_en   = en_i && push_ok;
  assign rd_en   = en_i && pop_ok;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q + {{(CW-1){1'b0}}, wr_en} - {{(CW-1){1'b0}}, rd_en};
    if (wr_en) begin
      tail_d = (tail_q == LastIdx) ? '0 : tail_q + AW'(1);
    end
    if (rd_en) begin
      head_d = (head_q == LastIdx) ? '0 : head_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // tail write and head read never meet in one cycle: needs an empty or full ring
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail_q] <= push_data_i;
    end
    if (rd_en) begin
      rdata_q <= mem[head_q];
    end
  end

  assign level_ext = {{urbp_pkg::LevelW{1'b0}}, count_d};

  assign st_o.push_ok   = push_ok;
  assign st_o.pop_ok    = pop_ok;
  assign st_o.empty_nxt = (count_d == '0);
  assign st_o.full_nxt  = (count_d == DepthC);
  assign level_o        = level_ext[urbp_pkg::LevelW-1:0];
  assign rdata_o        = rdata_q;

endmodule

[sv/urbp_out.sv]
// urbp_out: two-slot result pipe, access stage then output register
// uses urbp_pkg for the flags struct and result packing
`timescale 1ns / 1ps

module urbp_out (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       acc_i,
  input  urbp_pkg::urbp_flags_t      flags_i,
  input  logic [urbp_pkg::ByteW-1:0] rd_byte_i,
  input  logic [urbp_pkg::ByteW-1:0] tx_byte_i,
  output logic                       in_ready_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [urbp_pkg::OutW-1:0]  m_data_o
);

  logic                      a_v_q, a_v_d, out_v_q, out_v_d;
  urbp_pkg::urbp_flags_t     a_flags_q;
  logic [urbp_pkg::OutW-1:0] out_data_q;
  logic                      advance;

  // ring read data is held until the next accepted item, so the access slot can wait
  assign advance    = a_v_q && (!out_v_q || m_ready_i);
  assign in_ready_o = !a_v_q || advance;

  always_comb begin
    a_v_d   = a_v_q;
    out_v_d = out_v_q;
    if (acc_i) begin
      a_v_d = 1'b1;
    end else if (advance) begin
      a_v_d = 1'b0;
    end
    if (advance) begin
      out_v_d = 1'b1;
    end else if (m_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      a_v_q   <= a_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      a_flags_q <= flags_i;
    end
    if (advance) begin
      out_data_q <= urbp_pkg::pack_result(a_flags_q, rd_byte_i, tx_byte_i);
    end
  end

  assign m_valid_o = out_v_q;
  assign m_data_o  = out_data_q;

endmodule

[sv/uart_ring_buffer_pair.sv]
// uart_ring_buffer_pair: transmit and receive byte rings between a host and a uart
// result path: an accepted input item passes the access slot, then the output register, before it is offered
// throughput: one item per cycle while the result output is not back-pressured
// reset: heads, tails, counts and transmit irq bit cleared, receive irq bit set; stores not cleared
// depends on urbp_pkg, urbp_ring, urbp_out
`timescale 1ns / 1ps

module uart_ring_buffer_pair #(
  parameter int unsigned RX_DEPTH = 512,
  parameter int unsigned TX_DEPTH = 512
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // host_write_valid, host_write_byte, host_read_req, uart_tx_ready, uart_rx_valid,
  // uart_rx_byte, zero pad
  input  logic [urbp_pkg::InW-1:0]   s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // write_accepted, read_valid, read_byte, tx_out_valid, tx_out_byte, rx_taken,
  // tx_irq_enable, rx_irq_enable, tx_level, rx_level, zero pad
  output logic [urbp_pkg::OutW-1:0]  m_axis_tdata_o
);

  logic acc;
  logic wr_v, rd_req, tx_rdy, rx_v;
  logic [urbp_pkg::ByteW-1:0] wr_b, rx_b, tx_rdata, rx_rdata;
  logic [urbp_pkg::LevelW-1:0] tx_level, rx_level;
  urbp_pkg::urbp_ring_st_t tx_st, rx_st;
  urbp_pkg::urbp_flags_t flags;
  logic tx_irq_q, tx_irq_d, rx_irq_q, rx_irq_d;

  assign acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_v   = s_axis_tdata_i[urbp_pkg::InWrValid];
  assign wr_b   = s_axis_tdata_i[urbp_pkg::InWrByte +: urbp_pkg::ByteW];
  assign rd_req = s_axis_tdata_i[urbp_pkg::InRdReq];
  assign tx_rdy = s_axis_tdata_i[urbp_pkg::InTxReady];
  assign rx_v   = s_axis_tdata_i[urbp_pkg::InRxValid];
  assign rx_b   = s_axis_tdata_i[urbp_pkg::InRxByte +: urbp_pkg::ByteW];

  urbp_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
    .clk_i,
    .rst_ni,
    .en_i        (acc),
    .push_i      (wr_v),
    .push_data_i (wr_b),
    .pop_i       (tx_rdy),
    .st_o        (tx_st),
    .level_o     (tx_level),
    .rdata_o     (tx_rdata)
  );

  urbp_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
    .clk_i,
    .rst_ni,
    .en_i        (acc),
    .push_i      (rx_v),
    .push_data_i (rx_b),
    .pop_i       (rd_req),
    .st_o        (rx_st),
    .level_o     (rx_level),
    .rdata_o     (rx_rdata)
  );

  // irq bits follow the counts after the item
  always_comb begin
    tx_irq_d = tx_irq_q;
    rx_irq_d = rx_irq_q;
    if (acc) begin
      if (wr_v && !tx_st.empty_nxt) begin
        tx_irq_d = 1'b1;
      end
      if (tx_st.pop_ok && tx_st.empty_nxt) begin
        tx_irq_d = 1'b0;
      end
      if (rd_req && !rx_st.full_nxt) begin
        rx_irq_d = 1'b1;
      end
      if (rx_st.full_nxt) begin
        rx_irq_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_irq_q <= 1'b0;
      rx_irq_q <= 1'b1;
    end else begin
      tx_irq_q <= tx_irq_d;
      rx_irq_q <= rx_irq_d;
    end
  end

  assign flags.write_accepted = tx_st.push_ok;
  assign flags.read_valid     = rx_st.pop_ok;
  assign flags.tx_out_valid   = tx_st.pop_ok;
  assign flags.rx_taken       = rx_st.push_ok;
  assign flags.tx_irq_enable  = tx_irq_d;
  assign flags.rx_irq_enable  = rx_irq_d;
  assign flags.tx_level       = tx_level;
  assign flags.rx_level       = rx_level;

  urbp_out u_out (
    .clk_i,
    .rst_ni,
    .acc_i      (acc),
    .flags_i    (flags),
    .rd_byte_i  (rx_rdata),
    .tx_byte_i  (tx_rdata),
    .in_ready_o (s_axis_tready_o),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_data_o   (m_axis_tdata_o)
  );

  // an empty output register always leaves room for a new item
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output register");

  a_rx_irq_clear_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && rx_st.full_nxt) |=> !rx_irq_q)
    else $error("receive irq bit set with a full ring");

  a_tx_irq_clear_on_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && tx_st.pop_ok && tx_st.empty_nxt) |=> !tx_irq_q)
    else $error("transmit irq bit set after the ring drained");

endmodule

[tb/uart_ring_buffer_pair_tb.sv]
// uart_ring_buffer_pair_tb: self-checking bench for the transmit and receive byte rings
// streams host/uart items in, predicts each result from its own ring model and checks it
// depends on urbp_pkg and uart_ring_buffer_pair
`timescale 1ns / 1ps

module uart_ring_buffer_pair_tb;

  localparam int unsigned ByteW   = urbp_pkg::ByteW;
  localparam int unsigned LevelW  = urbp_pkg::LevelW;
  localparam int unsigned InW     = urbp_pkg::InW;
  localparam int unsigned OutW    = urbp_pkg::OutW;
  localparam int unsigned TxDepth = 512;
  localparam int unsigned RxDepth = 512;

  typedef struct {
    logic             wr_valid;
    logic [ByteW-1:0] wr_byte;
    logic             rd_req;
    logic             tx_ready;
    logic             rx_valid;
    logic [ByteW-1:0] rx_byte;
  } host_uart_item_t;

  typedef struct {
    logic              write_accepted;
    logic              read_valid;
    logic [ByteW-1:0]  read_byte;
    logic              tx_out_valid;
    logic [ByteW-1:0]  tx_out_byte;
    logic              rx_taken;
    logic              tx_irq_enable;
    logic              rx_irq_enable;
    logic [LevelW-1:0] tx_level;
    logic [LevelW-1:0] rx_level;
  } ring_result_t;

  logic            clk_i;
  logic            rst_ni         = 1'b0;
  logic            s_axis_tvalid  = 1'b0;
  logic            s_axis_tready_o;
  logic [InW-1:0]  s_axis_tdata   = '0;
  logic            m_axis_tvalid_o;
  logic            m_axis_tready  = 1'b0;
  logic [OutW-1:0] m_axis_tdata_o;

  // ring model state
  logic [ByteW-1:0] tx_mem [TxDepth];
  logic [ByteW-1:0] rx_mem [RxDepth];
  int unsigned      tx_head, tx_cnt, rx_head, rx_cnt;
  logic             tx_irq, rx_irq;

  ring_result_t pending_ring_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  src_idle_pct   = 0;
  int unsigned  sink_stall_pct = 0;

  uart_ring_buffer_pair #(
    .RX_DEPTH(RxDepth),
    .TX_DEPTH(TxDepth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic host_uart_item_t make_item(logic wv, logic [ByteW-1:0] wb, logic rd,
                                                logic tr, logic rv, logic [ByteW-1:0] rb);
    host_uart_item_t it;
    it.wr_valid = wv;
    it.wr_byte  = wb;
    it.rd_req   = rd;
    it.tx_ready = tr;
    it.rx_valid = rv;
    it.rx_byte  = rb;
    return it;
  endfunction

  function automatic logic [InW-1:0] pack_item(host_uart_item_t it);
    logic [InW-1:0] d;
    d                              = '0;
    d[urbp_pkg::InWrValid]         = it.wr_valid;
    d[urbp_pkg::InWrByte +: ByteW] = it.wr_byte;
    d[urbp_pkg::InRdReq]           = it.rd_req;
    d[urbp_pkg::InTxReady]         = it.tx_ready;
    d[urbp_pkg::InRxValid]         = it.rx_valid;
    d[urbp_pkg::InRxByte +: ByteW] = it.rx_byte;
    return d;
  endfunction

  function automatic ring_result_t unpack_result(logic [OutW-1:0] d);
    ring_result_t r;
    r.write_accepted = d[0];
    r.read_valid     = d[1];
    r.read_byte      = d[9:2];
    r.tx_out_valid   = d[10];
    r.tx_out_byte    = d[18:11];
    r.rx_taken       = d[19];
    r.tx_irq_enable  = d[20];
    r.rx_irq_enable  = d[21];
    r.tx_level       = d[31:22];
    r.rx_level       = d[41:32];
    return r;
  endfunction

  // one item of ring behaviour; every transfer is decided on the counts from before the item
  function automatic ring_result_t step_rings(host_uart_item_t it);
    ring_result_t r;
    logic ok_wr, ok_tx, ok_rd, ok_rx;
    ok_wr = it.wr_valid && (tx_cnt < TxDepth);
    ok_tx = it.tx_ready && (tx_cnt != 0);
    ok_rd = it.rd_req && (rx_cnt != 0);
    ok_rx = it.rx_valid && (rx_cnt < RxDepth);
    r.write_accepted = ok_wr;
    r.read_valid     = ok_rd;
    r.tx_out_valid   = ok_tx;
    r.rx_taken       = ok_rx;
    r.read_byte      = ok_rd ? rx_mem[rx_head] : '0;
    r.tx_out_byte    = ok_tx ? tx_mem[tx_head] : '0;
    if (ok_wr) tx_mem[(tx_head + tx_cnt) % TxDepth] = it.wr_byte;
    if (ok_rx) rx_mem[(rx_head + rx_cnt) % RxDepth] = it.rx_byte;
    if (ok_wr) tx_cnt++;
    if (ok_tx) begin
      tx_head = (tx_head + 1) % TxDepth;
      tx_cnt--;
    end
    if (ok_rx) rx_cnt++;
    if (ok_rd) begin
      rx_head = (rx_head + 1) % RxDepth;
      rx_cnt--;
    end
    if (it.wr_valid && tx_cnt > 0) tx_irq = 1'b1;
    if (ok_tx && tx_cnt == 0) tx_irq = 1'b0;
    if (it.rd_req && rx_cnt < RxDepth) rx_irq = 1'b1;
    if (rx_cnt == RxDepth) rx_irq = 1'b0;
    r.tx_irq_enable = tx_irq;
    r.rx_irq_enable = rx_irq;
    r.tx_level      = LevelW'(tx_cnt);
    r.rx_level      = LevelW'(rx_cnt);
    return r;
  endfunction

  task automatic check_field(string name, logic [LevelW-1:0] exp_v, logic [LevelW-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  task automatic check_result(ring_result_t exp_r, ring_result_t act_r, logic [5:0] pad);
    check_field("write_accepted", LevelW'(exp_r.write_accepted),
                LevelW'(act_r.write_accepted));
    check_field("read_valid", LevelW'(exp_r.read_valid), LevelW'(act_r.read_valid));
    check_field("read_byte", LevelW'(exp_r.read_byte), LevelW'(act_r.read_byte));
    check_field("tx_out_valid", LevelW'(exp_r.tx_out_valid), LevelW'(act_r.tx_out_valid));
    check_field("tx_out_byte", LevelW'(exp_r.tx_out_byte), LevelW'(act_r.tx_out_byte));
    check_field("rx_taken", LevelW'(exp_r.rx_taken), LevelW'(act_r.rx_taken));
    check_field("tx_irq_enable", LevelW'(exp_r.tx_irq_enable),
                LevelW'(act_r.tx_irq_enable));
    check_field("rx_irq_enable", LevelW'(exp_r.rx_irq_enable),
                LevelW'(act_r.rx_irq_enable));
    check_field("tx_level", exp_r.tx_level, act_r.tx_level);
    check_field("rx_level", exp_r.rx_level, act_r.rx_level);
    check_field("zero pad", '0, LevelW'(pad));
  endtask

  // result side: random back-pressure and in-order comparison
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      if (pending_ring_results.size() == 0) begin
        $display("%0t ns: result with nothing pending, expected none actual %h", $time,
                 m_axis_tdata_o);
        mismatch_count++;
      end else begin
        check_result(pending_ring_results.pop_front(), unpack_result(m_axis_tdata_o),
                     m_axis_tdata_o[OutW-1:42]);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_item(host_uart_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_item(it);
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_ring_results.push_back(step_rings(it));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_ring_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic chance(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [ByteW-1:0] any_byte();
    return ByteW'($urandom_range(255));
  endfunction

  // empty rings, byte extremes, transfers in mixes and all together
  task automatic test_directed();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_item(make_item(0, 8'h00, 0, 0, 0, 8'h00));
    send_item(make_item(0, 8'hFF, 1, 1, 0, 8'hFF));
    // write and ready on an empty ring: byte must not go straight out
    send_item(make_item(1, 8'hFF, 0, 1, 0, 8'h00));
    send_item(make_item(0, 8'h00, 0, 1, 0, 8'h00));
    send_item(make_item(1, 8'h00, 0, 0, 1, 8'h00));
    send_item(make_item(1, 8'hA5, 0, 0, 1, 8'hFF));
    send_item(make_item(1, 8'h5A, 1, 1, 1, 8'h5A));
    send_item(make_item(0, 8'h00, 1, 1, 0, 8'h00));
    send_item(make_item(0, 8'h00, 1, 1, 1, 8'h81));
    send_item(make_item(0, 8'h00, 1, 1, 0, 8'h00));
    send_item(make_item(0, 8'h00, 1, 1, 0, 8'h00));
    send_item(make_item(1, 8'h80, 1, 0, 1, 8'h01));
    send_item(make_item(1, 8'h01, 1, 1, 1, 8'h80));
    send_item(make_item(0, 8'h00, 1, 1, 0, 8'h00));
    send_item(make_item(0, 8'h00, 1, 1, 0, 8'h00));
    send_item(make_item(0, 8'h00, 1, 1, 0, 8'h00));
  endtask

  // push both rings to full, then work at the full boundary
  task automatic test_fill_to_full();
    src_idle_pct   = 66;
    sink_stall_pct = 0;
    while (tx_cnt < TxDepth || rx_cnt < RxDepth)
      send_item(make_item(1, any_byte(), chance(6), chance(6), 1, any_byte()));
    wait_drained();
    src_idle_pct = 0;
    send_item(make_item(1, any_byte(), 0, 0, 1, any_byte()));
    // take at full while the write is refused
    send_item(make_item(1, any_byte(), 0, 1, 1, any_byte()));
    // read at full with the uart byte refused, then refill
    send_item(make_item(0, any_byte(), 1, 0, 1, any_byte()));
    send_item(make_item(0, any_byte(), 0, 0, 1, any_byte()));
    send_item(make_item(1, any_byte(), 1, 1, 1, any_byte()));
    repeat (20)
      send_item(make_item(1, any_byte(), chance(30), chance(30), 1, any_byte()));
  endtask

  // empty both rings again, heads wrapping on the way
  task automatic test_drain_to_empty();
    src_idle_pct   = 0;
    sink_stall_pct = 66;
    while (tx_cnt != 0 || rx_cnt != 0)
      send_item(make_item(chance(6), any_byte(), 1, 1, chance(6), any_byte()));
    repeat (10)
      send_item(make_item(chance(50), any_byte(), chance(50), chance(50), chance(50),
                          any_byte()));
  endtask

  // bursts with random push and pop bias
  task automatic test_random_traffic();
    int unsigned p_in, p_out;
    for (int b = 0; b < 12; b++) begin
      src_idle_pct   = (b < 3) ? 0 : 28;
      sink_stall_pct = (b < 3) ? 0 : 28;
      p_in  = $urandom_range(100);
      p_out = $urandom_range(100);
      repeat (6)
        send_item(make_item(chance(p_in), any_byte(), chance(p_out), chance(p_out),
                            chance(p_in), any_byte()));
    end
  endtask

  initial begin
    tx_head = 0;
    tx_cnt  = 0;
    rx_head = 0;
    rx_cnt  = 0;
    tx_irq  = 1'b0;
    rx_irq  = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_to_full();
    test_drain_to_empty();
    test_random_traffic();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
